FILE: sv/btd_pkg.sv
`timescale 1ns / 1ps
package btd_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int ID_W        = $clog2(NUM_TIMERS);
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 32;
  localparam int PER_W       = 24;
  localparam int COST_W      = 8;
  localparam int CFG_W       = 16;
  localparam int ADDR_W      = 4;

  localparam logic [1:0] OP_SCHED  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_FIRE   = 2'd2;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_NUM    = 2'd1;
  localparam logic [1:0] REG_DEN    = 2'd2;
  localparam logic [1:0] REG_CAP    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCHED,
    S_FCLR,
    S_FMUL,
    S_FADD,
    S_SCAN,
    S_PICK,
    S_NEED,
    S_CHECK,
    S_PUSH,
    S_DIV,
    S_REARM,
    S_NEXT,
    S_FINISH
  } state_t;

endpackage

FILE: sv/btd_rem_div.sv
`timescale 1ns / 1ps
module btd_rem_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [btd_pkg::TIME_W-1:0] dividend,
  input  logic [btd_pkg::PER_W-1:0]  divisor,
  output logic                      done,
  output logic [btd_pkg::PER_W-1:0]  rem
);
  import btd_pkg::*;

  localparam int STEP_W = $clog2(TIME_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [TIME_W-1:0] dvd;
  logic [PER_W-1:0]  dsr;
  logic [PER_W:0]    shifted;
  logic [PER_W:0]    diff;

  assign shifted = {rem, dvd[TIME_W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd <= {dvd[TIME_W-2:0], 1'b0};
        rem <= diff[PER_W] ? shifted[PER_W-1:0] : diff[PER_W-1:0];
        step <= step + 1'b1;
        if (step == STEP_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/budgeted_timer_dispatcher.sv
`timescale 1ns / 1ps
// Budgeted timer dispatcher: 16 timer slots drained by fire requests under a
// token bucket.
// Input channel: in_valid/in_stall with opcode, timer_id, time_value, period
// and cost. A request is taken when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall with fired_id, fired_valid,
// last_of_run. A fire gives one result per dispatched slot, last_of_run on
// the final one, or a single empty result when nothing is dispatched.
// Schedule passes through a write state; cancel and unknown opcodes are
// handled in idle. A fire clears, multiplies and adds the refill, then per
// dispatched slot runs a scan of the slots, pick, cost multiply, budget
// check, push and step; a recurring slot's re-arm waits on a bit-serial
// remainder unit. A closing scan, pick and finish end the run (with cost
// multiply and check when the budget stops it, finish alone after the
// sixteenth dispatch). Only one request is in work at a time; in_stall is
// high until its last result sits in the output register.
// A stall on the output holds the result register and the sequencer waits.
// Configuration is via the APB-style port and must only be written idle.
// Reset (rst, synchronous) empties all slots, clears marks, the order
// counter, the bucket and the last fire time; no clearing pass is needed.
module budgeted_timer_dispatcher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [btd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [btd_pkg::ID_W-1:0]    timer_id,
  input  logic [btd_pkg::TIME_W-1:0]  time_value,
  input  logic [btd_pkg::PER_W-1:0]   period,
  input  logic [btd_pkg::COST_W-1:0]  cost,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [btd_pkg::ID_W-1:0]    fired_id,
  output logic                        fired_valid,
  output logic                        last_of_run
);
  import btd_pkg::*;

  state_t state, state_next;

  logic             cfg_en;
  logic [CFG_W-1:0] cfg_num, cfg_den, cfg_cap;
  logic [31:0]      cap_units;

  logic [TIME_W-1:0] ready_mem [NUM_TIMERS];
  logic [TIME_W-1:0] order_mem [NUM_TIMERS];
  logic [PER_W-1:0]  per_mem   [NUM_TIMERS];
  logic [COST_W-1:0] cost_mem  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] valid_vec, cancel_vec, taken_vec;

  logic [ID_W-1:0]   idx;
  logic [TIME_W-1:0] now;
  logic [PER_W-1:0]  sch_per;
  logic [COST_W-1:0] sch_cost;
  logic [TIME_W-1:0] order_cnt, budget, last_time;
  logic [47:0]       add_reg;
  logic [23:0]       need;
  logic [CNT_W-1:0]  n_disp;
  logic              hold_valid;
  logic [ID_W-1:0]   hold_id;
  logic              best_found;
  logic [ID_W-1:0]   best_idx;
  logic [TIME_W-1:0] best_ready, best_order;

  logic [TIME_W-1:0] rd_ready, rd_order;
  logic [PER_W-1:0]  rd_per;
  logic              accept, out_free, cand, better, afford, push_go, div_start, div_done;
  logic              out_load;
  logic [PER_W-1:0]  div_rem;
  logic [32:0]       rearm_sum;
  logic [48:0]       refill_sum;
  logic              cfg_wr;

  assign rd_ready = ready_mem[idx];
  assign rd_order = order_mem[idx];
  assign rd_per   = per_mem[idx];

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cand     = valid_vec[idx] && !taken_vec[idx] && (rd_ready <= now);
  assign better   = !best_found || (rd_ready < best_ready) ||
                    ((rd_ready == best_ready) && (rd_order < best_order));
  assign afford   = !cfg_en || (budget >= {8'd0, need});
  assign push_go  = !(hold_valid && !out_free);
  assign rearm_sum  = {1'b0, now} - {9'd0, div_rem} + {9'd0, rd_per};
  assign refill_sum = {17'd0, budget} + {1'b0, add_reg};
  assign cfg_wr     = psel && penable && pwrite && pready;

  btd_rem_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (now - rd_ready),
    .divisor  (rd_per),
    .done     (div_done),
    .rem      (div_rem)
  );

  // configuration
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_ENABLE: prdata = {31'd0, cfg_en};
      REG_NUM:    prdata = {16'd0, cfg_num};
      REG_DEN:    prdata = {16'd0, cfg_den};
      REG_CAP:    prdata = {16'd0, cfg_cap};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_en    <= 1'b0;
      cfg_num   <= '0;
      cfg_den   <= CFG_W'(1);
      cfg_cap   <= '0;
      cap_units <= '0;
    end else begin
      cap_units <= cfg_cap * cfg_den;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ENABLE: cfg_en  <= pwdata[0];
          REG_NUM:    cfg_num <= pwdata[CFG_W-1:0];
          REG_DEN:    cfg_den <= pwdata[CFG_W-1:0];
          REG_CAP:    cfg_cap <= pwdata[CFG_W-1:0];
          default:    cfg_en  <= cfg_en;
        endcase
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (opcode)
            OP_SCHED: state_next = S_SCHED;
            OP_FIRE:  state_next = S_FCLR;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_SCHED:  state_next = S_IDLE;
      S_FCLR:   state_next = S_FMUL;
      S_FMUL:   state_next = S_FADD;
      S_FADD:   state_next = S_SCAN;
      S_SCAN:   if (idx == ID_W'(NUM_TIMERS - 1)) state_next = S_PICK;
      S_PICK:   state_next = best_found ? S_NEED : S_FINISH;
      S_NEED:   state_next = S_CHECK;
      S_CHECK:  state_next = afford ? S_PUSH : S_FINISH;
      S_PUSH: begin
        if (push_go) state_next = (rd_per == '0) ? S_NEXT : S_DIV;
      end
      S_DIV:    if (div_done) state_next = S_REARM;
      S_REARM:  state_next = S_NEXT;
      S_NEXT:   state_next = (n_disp == CNT_W'(MAX_RESULTS)) ? S_FINISH : S_SCAN;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state != S_IDLE);
    div_start = (state == S_PUSH) && push_go && (rd_per != '0);
    out_load  = ((state == S_PUSH) && push_go && hold_valid) ||
                ((state == S_FINISH) && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_vec  <= '0;
      cancel_vec <= '0;
      taken_vec  <= '0;
      order_cnt  <= '0;
      budget     <= '0;
      last_time  <= '0;
      hold_valid <= 1'b0;
      best_found <= 1'b0;
      n_disp     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (!(state inside {S_FADD, S_CHECK}))
        budget <= (budget > cap_units) ? cap_units : budget;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx      <= timer_id;
            now      <= time_value;
            sch_per  <= period;
            sch_cost <= cost;
            if (opcode == OP_CANCEL) cancel_vec[timer_id] <= 1'b1;
          end
        end
        S_SCHED: begin
          if (!valid_vec[idx]) begin
            valid_vec[idx] <= 1'b1;
            ready_mem[idx] <= now;
            order_mem[idx] <= order_cnt;
            order_cnt      <= order_cnt + 1'b1;
          end else if (now < rd_ready) begin
            ready_mem[idx] <= now;
          end
          per_mem[idx]  <= sch_per;
          cost_mem[idx] <= sch_cost;
        end
        S_FCLR: begin
          valid_vec  <= valid_vec & ~cancel_vec;
          cancel_vec <= '0;
          taken_vec  <= '0;
          n_disp     <= '0;
          hold_valid <= 1'b0;
        end
        S_FMUL: begin
          add_reg   <= (cfg_en && now > last_time) ? (now - last_time) * cfg_num : '0;
          last_time <= now;
        end
        S_FADD: begin
          if (cfg_en)
            budget <= (refill_sum > {17'd0, cap_units}) ? cap_units : refill_sum[31:0];
          idx        <= '0;
          best_found <= 1'b0;
        end
        S_SCAN: begin
          if (cand && better) begin
            best_found <= 1'b1;
            best_idx   <= idx;
            best_ready <= rd_ready;
            best_order <= rd_order;
          end
          idx <= idx + 1'b1;
        end
        S_PICK:  idx  <= best_idx;
        S_NEED:  need <= cost_mem[idx] * cfg_den;
        S_CHECK: begin
          if (afford) begin
            if (cfg_en) budget <= budget - {8'd0, need};
            taken_vec[idx] <= 1'b1;
            n_disp         <= n_disp + 1'b1;
          end
        end
        S_PUSH: begin
          if (push_go) begin
            if (hold_valid) begin
              fired_id    <= hold_id;
              fired_valid <= 1'b1;
              last_of_run <= 1'b0;
            end
            hold_valid <= 1'b1;
            hold_id    <= idx;
            if (rd_per == '0) valid_vec[idx] <= 1'b0;
          end
        end
        S_REARM: begin
          ready_mem[idx] <= rearm_sum[32] ? '1 : rearm_sum[31:0];
          order_mem[idx] <= order_cnt;
          order_cnt      <= order_cnt + 1'b1;
        end
        S_NEXT: begin
          idx        <= '0;
          best_found <= 1'b0;
        end
        S_FINISH: begin
          if (out_free) begin
            fired_id    <= hold_valid ? hold_id : '0;
            fired_valid <= hold_valid;
            last_of_run <= 1'b1;
            hold_valid  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
